FILE: rtl/core/mfb_pkg.sv
`default_nettype none
package mfb_pkg;

    localparam int NODES_DEF    = 8;
    localparam int CAP_BITS_DEF = 16;

    // fixed field widths
    localparam int NODE_W = 3;
    localparam int CAP_W  = 16;
    localparam int FLOW_W = 19;

    // bottleneck seed of each augmenting walk
    localparam logic [23:0] PATH_INIT = 24'hffffff;

    // datapath commands
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_INIT,
        CMD_DEQ_TAKE,
        CMD_SCAN_RD,
        CMD_SCAN_CHK,
        CMD_WALK_START,
        CMD_PATH_RD,
        CMD_WALK_MIN,
        CMD_AUG_START,
        CMD_AUG_FWD,
        CMD_AUG_REV,
        CMD_ADD_FLOW,
        CMD_EMIT
    } mfb_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic start_bad;
        logic deq_empty;
        logic sink_seen;
        logic scan_last;
        logic at_source;
        logic out_busy;
    } mfb_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/max_flow_bfs_augment.sv
`default_nettype none
// Channel   Direction  Handshake            Word
// ------    ---------  -------------------  ---------------------------------------
// in        input      in_valid / in_stall  from_node, to_node, capacity, last_edge
// out       output     out_valid/out_stall  total_flow
// cfg       input      cfg_write            cfg_index (0 source, 1 sink), cfg_data
//
// Edge words load one per cycle, while in_stall is low, into the residual store (RAM
// with one write and one registered read port). The word with last_edge starts
// Edmonds-Karp; in_stall stays high until the result is registered and the store
// is cleared. Each round runs a BFS scan and then a path walk and augment, all
// paced by the RAM read port.
// After reset and after each result a clearing pass zeroes all 4^clog2(NODES)
// entries of the store (64 at 8 nodes); edges are stalled meanwhile.
// The output register holds a result while out_stall is high; new edges are
// still accepted during that time.
module max_flow_bfs_augment #(
    parameter int NODES    = mfb_pkg::NODES_DEF,
    parameter int CAP_BITS = mfb_pkg::CAP_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic                       cfg_index,
    input  wire logic [mfb_pkg::NODE_W-1:0] cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [mfb_pkg::NODE_W-1:0] from_node,
    input  wire logic [mfb_pkg::NODE_W-1:0] to_node,
    input  wire logic [mfb_pkg::CAP_W-1:0]  capacity,
    input  wire logic                       last_edge,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [mfb_pkg::FLOW_W-1:0]      total_flow
);
    import mfb_pkg::*;

    mfb_cmd_t    cmd;     // controller -> datapath
    mfb_status_t status;  // datapath -> controller

    mfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .last_edge (last_edge),
        .status    (status),
        .cmd       (cmd)
    );

    // residual RAM, BFS queue, predecessors, bottleneck and flow accumulator
    mfb_datapath #(
        .NODES    (NODES),
        .CAP_BITS (CAP_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .from_node  (from_node),
        .to_node    (to_node),
        .capacity   (capacity),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .total_flow (total_flow)
    );

endmodule
`default_nettype wire

FILE: rtl/core/mfb_datapath.sv
`default_nettype none
module mfb_datapath #(
    parameter int NODES    = mfb_pkg::NODES_DEF,
    parameter int CAP_BITS = mfb_pkg::CAP_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mfb_pkg::mfb_cmd_t          cmd,
    output mfb_pkg::mfb_status_t            status,
    input  wire logic                       cfg_write,
    input  wire logic                       cfg_index,
    input  wire logic [mfb_pkg::NODE_W-1:0] cfg_data,
    input  wire logic [mfb_pkg::NODE_W-1:0] from_node,
    input  wire logic [mfb_pkg::NODE_W-1:0] to_node,
    input  wire logic [mfb_pkg::CAP_W-1:0]  capacity,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [mfb_pkg::FLOW_W-1:0]      total_flow
);
    import mfb_pkg::*;

    localparam int NW    = $clog2(NODES);
    localparam int AW    = 2 * NW;
    localparam int DEPTH = 1 << AW;
    localparam int RES_W = CAP_BITS + 1;
    localparam int CMP_W = (RES_W > 24) ? RES_W : 24;
    localparam logic [CAP_W-1:0] CAP_MASK =
        (CAP_BITS >= CAP_W) ? {CAP_W{1'b1}} : CAP_W'((64'd1 << CAP_BITS) - 64'd1);

    logic [NODE_W-1:0] source_reg, sink_reg;
    logic [NODES-1:0]  visited_reg;
    logic [NW:0]       head_reg, tail_reg;
    logic [NW-1:0]     u_reg, cur_reg, v_reg;
    logic [CMP_W-1:0]  neck_reg;
    logic [FLOW_W-1:0] flow_reg, total_flow_reg;
    logic [AW-1:0]     clr_reg;
    logic              out_valid_reg;

    logic [RES_W-1:0]  res_mem [DEPTH];
    logic [NW-1:0]     pred_mem [1 << NW];
    logic [NW-1:0]     queue_mem [1 << NW];
    logic [RES_W-1:0]  res_q;
    logic [NW-1:0]     pred_q, queue_q;

    logic              res_we;
    logic [AW-1:0]     res_waddr, res_raddr;
    logic [RES_W-1:0]  res_wdata;
    logic [NW-1:0]     src_n, dst_n, from_n, to_n;
    logic [RES_W-1:0]  neck_r;
    logic              edge_ok, discover;

    assign src_n   = NW'(source_reg);
    assign dst_n   = NW'(sink_reg);
    assign from_n  = NW'(from_node);
    assign to_n    = NW'(to_node);
    assign neck_r  = RES_W'(neck_reg);
    assign edge_ok = (32'(from_node) < 32'(NODES)) && (32'(to_node) < 32'(NODES));
    assign discover = !visited_reg[v_reg] && (res_q != '0);

    always_comb
    begin
        res_we    = 1'b0;
        res_waddr = '0;
        res_wdata = '0;
        res_raddr = '0;
        case (cmd)
            CMD_CLEAR:
            begin
                res_we    = 1'b1;
                res_waddr = clr_reg;
            end
            CMD_LOAD:
            begin
                res_we    = edge_ok;
                res_waddr = {from_n, to_n};
                res_wdata = RES_W'(capacity & CAP_MASK);
            end
            CMD_SCAN_RD: res_raddr = {u_reg, v_reg};
            CMD_PATH_RD: res_raddr = {pred_q, cur_reg};
            CMD_AUG_FWD:
            begin
                res_we    = 1'b1;
                res_waddr = {u_reg, cur_reg};
                res_wdata = res_q - neck_r;
                res_raddr = {cur_reg, u_reg};
            end
            CMD_AUG_REV:
            begin
                res_we    = 1'b1;
                res_waddr = {cur_reg, u_reg};
                res_wdata = res_q + neck_r;
            end
            default: ;
        endcase
    end

    // residual store, registered read
    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[res_waddr] <= res_wdata;
        res_q <= res_mem[res_raddr];
    end

    // predecessor and search queue stores
    always_ff @(posedge clk)
    begin
        if (cmd == CMD_SCAN_CHK && discover)
            pred_mem[v_reg] <= u_reg;
        pred_q <= pred_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_INIT)
            queue_mem[0] <= src_n;
        else if (cmd == CMD_SCAN_CHK && discover)
            queue_mem[tail_reg[NW-1:0]] <= v_reg;
        queue_q <= queue_mem[head_reg[NW-1:0]];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg    <= '0;
            sink_reg      <= 3'd7;
            head_reg      <= '0;
            tail_reg      <= '0;
            flow_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index)
                    sink_reg <= cfg_data;
                else
                    source_reg <= cfg_data;
            end
            // emit only when the output register is free or taken this cycle
            if (cmd == CMD_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (cmd)
                CMD_CLEAR: clr_reg <= clr_reg + 1'b1;
                CMD_INIT:
                begin
                    head_reg <= '0;
                    tail_reg <= (NW+1)'(1);
                end
                CMD_DEQ_TAKE: head_reg <= head_reg + 1'b1;
                CMD_SCAN_CHK:
                    if (discover)
                        tail_reg <= tail_reg + 1'b1;
                CMD_ADD_FLOW: flow_reg <= flow_reg + neck_reg[FLOW_W-1:0];
                CMD_EMIT:     flow_reg <= '0;
                default: ;
            endcase
        end
    end

    // search and path payload
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_INIT: visited_reg <= NODES'(1) << src_n;
            CMD_DEQ_TAKE:
            begin
                u_reg <= queue_q;
                v_reg <= '0;
            end
            CMD_SCAN_CHK:
            begin
                v_reg <= v_reg + 1'b1;
                if (discover)
                    visited_reg[v_reg] <= 1'b1;
            end
            CMD_WALK_START:
            begin
                neck_reg <= CMP_W'(PATH_INIT);
                cur_reg  <= dst_n;
            end
            CMD_PATH_RD: u_reg <= pred_q;
            CMD_WALK_MIN:
            begin
                if (CMP_W'(res_q) < neck_reg)
                    neck_reg <= CMP_W'(res_q);
                cur_reg <= u_reg;
            end
            CMD_AUG_START: cur_reg <= dst_n;
            CMD_AUG_REV:   cur_reg <= u_reg;
            CMD_EMIT:      total_flow_reg <= flow_reg;
            default: ;
        endcase
    end

    assign status.clear_last = &clr_reg;
    assign status.start_bad  = (32'(source_reg) >= 32'(NODES)) ||
                               (32'(sink_reg) >= 32'(NODES)) || (source_reg == sink_reg);
    assign status.deq_empty  = (head_reg == tail_reg);
    assign status.sink_seen  = visited_reg[dst_n];
    assign status.scan_last  = (v_reg == NW'(NODES - 1));
    assign status.at_source  = (cur_reg == src_n);
    assign status.out_busy   = out_valid_reg && out_stall;

    assign out_valid  = out_valid_reg;
    assign total_flow = total_flow_reg;

    ap_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg) else $error("queue head passed tail");
    ap_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(tail_reg) <= 32'(NODES)) else $error("queue overflow");
    ap_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd == CMD_EMIT)) else $error("stray result");

endmodule
`default_nettype wire

FILE: rtl/core/mfb_ctrl.sv
`default_nettype none
module mfb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 last_edge,
    input  wire mfb_pkg::mfb_status_t status,
    output mfb_pkg::mfb_cmd_t         cmd
);
    import mfb_pkg::*;

    typedef enum logic [15:0] {
        ST_CLEAR  = 16'h0001,
        ST_IDLE   = 16'h0002,
        ST_START  = 16'h0004,
        ST_INIT   = 16'h0008,
        ST_DEQ    = 16'h0010,
        ST_DEQ_W  = 16'h0020,
        ST_SCAN   = 16'h0040,
        ST_CHK    = 16'h0080,
        ST_WALK   = 16'h0100,
        ST_WALK_P = 16'h0200,
        ST_WALK_C = 16'h0400,
        ST_AUG    = 16'h0800,
        ST_AUG_P  = 16'h1000,
        ST_AUG_F  = 16'h2000,
        ST_AUG_R  = 16'h4000,
        ST_DONE   = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd = CMD_CLEAR;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
                if (in_valid)
                begin
                    cmd = CMD_LOAD;
                    if (last_edge)
                        state_next = ST_START;
                end
            ST_START: state_next = status.start_bad ? ST_DONE : ST_INIT;
            ST_INIT:
            begin
                cmd        = CMD_INIT;
                state_next = ST_DEQ;
            end
            ST_DEQ:
                if (!status.deq_empty)
                    state_next = ST_DEQ_W;
                else if (status.sink_seen)
                begin
                    cmd        = CMD_WALK_START;
                    state_next = ST_WALK;
                end
                else
                    state_next = ST_DONE;
            ST_DEQ_W:
            begin
                cmd        = CMD_DEQ_TAKE;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd        = CMD_SCAN_RD;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                cmd        = CMD_SCAN_CHK;
                state_next = status.scan_last ? ST_DEQ : ST_SCAN;
            end
            ST_WALK:
                if (status.at_source)
                begin
                    cmd        = CMD_AUG_START;
                    state_next = ST_AUG;
                end
                else
                    state_next = ST_WALK_P;
            ST_WALK_P:
            begin
                cmd        = CMD_PATH_RD;
                state_next = ST_WALK_C;
            end
            ST_WALK_C:
            begin
                cmd        = CMD_WALK_MIN;
                state_next = ST_WALK;
            end
            ST_AUG:
                if (status.at_source)
                begin
                    cmd        = CMD_ADD_FLOW;
                    state_next = ST_INIT;
                end
                else
                    state_next = ST_AUG_P;
            ST_AUG_P:
            begin
                cmd        = CMD_PATH_RD;
                state_next = ST_AUG_F;
            end
            ST_AUG_F:
            begin
                cmd        = CMD_AUG_FWD;
                state_next = ST_AUG_R;
            end
            ST_AUG_R:
            begin
                cmd        = CMD_AUG_REV;
                state_next = ST_AUG;
            end
            ST_DONE:
                if (!status.out_busy)
                begin
                    cmd        = CMD_EMIT;
                    state_next = ST_CLEAR;
                end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire
